/* design/sprite_frame_sequencer_unit_assert.svh */
// Assertion macros for the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, disabled in reset.
`define SFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

/* design/sfs_pkg.sv */
package sfs_pkg;

  // Sizes
  localparam int ROWS       = 8;
  localparam int MAX_FRAMES = 16;
  localparam int MODE_W     = 2;
  localparam int TIME_W     = 16;
  localparam int ACC_W      = 17;
  localparam int ROW_W      = 3;
  localparam int STYLE_W    = 2;
  localparam int FRAME_W    = 4;
  localparam int PACKED_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUEUE = 2'd2;

  // Play styles (code 3 plays as loop)
  localparam logic [STYLE_W-1:0] STYLE_LOOP     = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_ONCE     = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_PINGPONG = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ROW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STYLE  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  elapsed;
    logic [ROW_W-1:0]   anim_row;
    logic [TIME_W-1:0]  frame_period;
    logic [STYLE_W-1:0] play_style;
  } sfs_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [ROW_W-1:0]   row_index;
    logic               going_forward;
    logic               frame_changed;
  } sfs_result_t;

  typedef struct packed {
    logic [PACKED_W-1:0] frames_per_row_packed;
    logic [ROW_W-1:0]    default_row;
    logic [TIME_W-1:0]   default_period;
    logic [STYLE_W-1:0]  default_style;
  } sfs_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0]   time_accum;
    logic [ROW_W-1:0]   cur_row;
    logic [TIME_W-1:0]  cur_period;
    logic [STYLE_W-1:0] cur_style;
    logic [FRAME_W-1:0] frame_pos;
    logic               forward_flag;
    logic [ROW_W-1:0]   queued_row;
    logic [TIME_W-1:0]  queued_period;
    logic [STYLE_W-1:0] queued_style;
  } sfs_state_t;

  localparam sfs_state_t STATE_RESET = '{
    time_accum: '0, cur_row: '0, cur_period: '0, cur_style: STYLE_LOOP,
    frame_pos: '0, forward_flag: 1'b1, queued_row: '0, queued_period: '0,
    queued_style: '0
  };

  // Last frame index of a row; rows past ROWS hold one frame
  function automatic logic [FRAME_W-1:0] last_frame(logic [PACKED_W-1:0] pk,
                                                    logic [ROW_W-1:0] row);
    logic [FRAME_W-1:0] n;
    n = pk[{row, 2'b00} +: FRAME_W];
    if (int'(row) >= ROWS) begin
      n = '0;
    end else if (int'(n) > MAX_FRAMES - 1) begin
      n = FRAME_W'(MAX_FRAMES - 1);
    end
    return n;
  endfunction

endpackage

/* design/sfs_item_if.sv */
interface sfs_item_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [TIME_W-1:0]  elapsed;
  logic [ROW_W-1:0]   anim_row;
  logic [TIME_W-1:0]  frame_period;
  logic [STYLE_W-1:0] play_style;

  modport source (output valid, mode, elapsed, anim_row, frame_period, play_style,
                  input ready);
  modport sink (input valid, mode, elapsed, anim_row, frame_period, play_style,
                output ready);
endinterface

/* design/sfs_result_if.sv */
interface sfs_result_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;
  logic [ROW_W-1:0]   row_index;
  logic               going_forward;
  logic               frame_changed;

  modport source (output valid, frame_index, row_index, going_forward, frame_changed,
                  input ready);
  modport sink (input valid, frame_index, row_index, going_forward, frame_changed,
                output ready);
endinterface

/* design/sfs_cfg_if.sv */
interface sfs_cfg_if import sfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/sfs_cfg_regs.sv */
module sfs_cfg_regs import sfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sfs_cfg_if.sink  cfg,
  output sfs_cfg_t regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FRAMES_PER_ROW: regs.frames_per_row_packed <= cfg.data;
        CFG_DEFAULT_ROW:    regs.default_row    <= cfg.data[ROW_W-1:0];
        CFG_DEFAULT_PERIOD: regs.default_period <= cfg.data[TIME_W-1:0];
        CFG_DEFAULT_STYLE:  regs.default_style  <= cfg.data[STYLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/sfs_step.sv */
module sfs_step import sfs_pkg::*; (
  input  sfs_item_t   item,
  input  sfs_state_t  state,
  input  sfs_cfg_t    regs,
  output sfs_state_t  state_next,
  output sfs_result_t res
);

  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   acc_sat;
  logic               step;
  logic [FRAME_W-1:0] last;
  logic               changed;

  // Saturating accumulate and period compare
  assign sum     = {1'b0, state.time_accum} + (ACC_W+1)'(item.elapsed);
  assign acc_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  assign step    = acc_sat >= ACC_W'(state.cur_period);
  assign last    = last_frame(regs.frames_per_row_packed, state.cur_row);

  // Next state
  always_comb begin
    state_next = state;
    changed    = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        state_next.time_accum = acc_sat;
        if (step) begin
          state_next.time_accum = acc_sat - ACC_W'(state.cur_period);
          if (state.forward_flag && state.frame_pos < last) begin
            state_next.frame_pos = state.frame_pos + 1'b1;
          end else if (!state.forward_flag && state.frame_pos != '0) begin
            state_next.frame_pos = state.frame_pos - 1'b1;
          end else if (state.queued_period != '0) begin
            // end of run: queued animation takes over
            state_next.cur_row       = state.queued_row;
            state_next.cur_period    = state.queued_period;
            state_next.cur_style     = state.queued_style;
            state_next.frame_pos     = '0;
            state_next.forward_flag  = 1'b1;
            state_next.queued_row    = '0;
            state_next.queued_period = '0;
            state_next.queued_style  = '0;
          end else if (state.cur_style == STYLE_ONCE) begin
            // end of run: back to default
            state_next.cur_row       = regs.default_row;
            state_next.cur_period    = regs.default_period;
            state_next.cur_style     = regs.default_style;
            state_next.frame_pos     = '0;
            state_next.forward_flag  = 1'b1;
            state_next.queued_row    = '0;
            state_next.queued_period = '0;
            state_next.queued_style  = '0;
          end else if (state.cur_style == STYLE_PINGPONG) begin
            // end of run: reverse
            if (state.forward_flag) begin
              if (state.frame_pos != '0) state_next.frame_pos = state.frame_pos - 1'b1;
            end else begin
              if (state.frame_pos < last) state_next.frame_pos = state.frame_pos + 1'b1;
            end
            state_next.forward_flag = !state.forward_flag;
          end else begin
            state_next.frame_pos = '0;
          end
        end
        changed = (state_next.frame_pos  != state.frame_pos)  ||
                  (state_next.cur_row    != state.cur_row)    ||
                  (state_next.cur_period != state.cur_period) ||
                  (state_next.cur_style  != state.cur_style);
      end
      MODE_SET: begin
        state_next.cur_row       = item.anim_row;
        state_next.cur_period    = item.frame_period;
        state_next.cur_style     = item.play_style;
        state_next.frame_pos     = '0;
        state_next.forward_flag  = 1'b1;
        state_next.queued_row    = '0;
        state_next.queued_period = '0;
        state_next.queued_style  = '0;
        changed                  = 1'b1;
      end
      MODE_QUEUE: begin
        state_next.queued_row    = item.anim_row;
        state_next.queued_period = item.frame_period;
        state_next.queued_style  = item.play_style;
      end
      default: ;
    endcase
  end

  // Result fields
  assign res.frame_index   = state_next.frame_pos;
  assign res.row_index     = state_next.cur_row;
  assign res.going_forward = state_next.forward_flag;
  assign res.frame_changed = changed;

endmodule

/* design/sfs_core.sv */
`include "sprite_frame_sequencer_unit_assert.svh"

module sfs_core import sfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sfs_cfg_t   regs,
  sfs_item_if.sink   item,
  sfs_result_if.source result
);

  logic        s1_valid;
  sfs_item_t   s1_item;
  sfs_item_t   in_item;
  logic        adv;
  sfs_state_t  state;
  sfs_state_t  state_next;
  logic        res_valid;
  sfs_result_t res;
  sfs_result_t res_next;

  // Handshake: stage moves when the result register is free or being drained
  assign adv        = !res_valid || result.ready;
  assign item.ready = !s1_valid || adv;

  assign in_item = '{mode: item.mode, elapsed: item.elapsed, anim_row: item.anim_row,
                     frame_period: item.frame_period, play_style: item.play_style};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      s1_item <= in_item;
    end
  end

  sfs_step u_step (
    .item       (s1_item),
    .state      (state),
    .regs       (regs),
    .state_next (state_next),
    .res        (res_next)
  );

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
    if (adv && s1_valid) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.frame_index   = res.frame_index;
  assign result.row_index     = res.row_index;
  assign result.going_forward = res.going_forward;
  assign result.frame_changed = res.frame_changed;

  // Checks
  `SFS_ASSERT_NEXT(a_hold_item, clk, rst, s1_valid && !adv, s1_valid)
  `SFS_ASSERT_NEXT(a_state_idle, clk, rst, !(s1_valid && adv), $stable(state))
  `SFS_ASSERT_NEXT(a_set_result, clk, rst, s1_valid && adv && s1_item.mode == MODE_SET,
                   res.frame_changed && res.frame_index == '0 && res.going_forward)
  `SFS_ASSERT_NEXT(a_queue_quiet, clk, rst, s1_valid && adv && s1_item.mode == MODE_QUEUE,
                   !res.frame_changed && res_valid)

endmodule

/* design/sprite_frame_sequencer_unit.sv */
// Channel   Role    Handshake      Payload
// item      sink    valid/ready    mode, elapsed, anim_row, frame_period, play_style
// result    source  valid/ready    frame_index, row_index, going_forward, frame_changed
// cfg       sink    valid/ready    index, data (ready always high)
//
// A request passes through the input register, then the step logic into the state and
// result registers. Throughput: one request per cycle while result.ready stays high.
// Reset (rst, synchronous) clears config to 0 and state to frame 0, forward, empty queue.
// A stalled result holds; the input register then fills and item.ready drops.
module sprite_frame_sequencer_unit import sfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sfs_item_if.sink     item,
  sfs_result_if.source result,
  sfs_cfg_if.sink      cfg
);

  sfs_cfg_t regs;

  sfs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sfs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .item   (item),
    .result (result)
  );

endmodule
